/* src/hprt_pkg.sv */
//------------------------------------------------------------------------------
// hprt_pkg
// Shared constants, types and hash helper for the hashed path route table.
//------------------------------------------------------------------------------
`default_nettype none
package hprt_pkg;
    localparam int TABLE_SLOTS    = 256;
    localparam int MAX_PATH_BYTES = 128;
    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int STEP_W  = SLOT_W + 1;
    localparam int BYTE_W  = $clog2(MAX_PATH_BYTES);
    localparam int LEN_W   = $clog2(MAX_PATH_BYTES + 1);
    localparam int KEY_AW  = SLOT_W + BYTE_W;
    localparam int HALF_SLOTS = (TABLE_SLOTS + 1) / 2;

    localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
    localparam logic [15:0] EMPTY_ROUTE = 16'hFFFF;
    localparam logic [7:0]  CHAR_QUERY  = 8'h3F;
    localparam logic [7:0]  CHAR_HASH   = 8'h23;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_LOOKUP    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_COMPARE,
        S_COPY
    } t_state;

    typedef struct packed {
        logic [15:0]      route;
        logic [7:0]       method;
        logic [LEN_W-1:0] length;
    } t_meta;

    // FNV-1a step; prime is 2^40 + 0x1b3
    function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x * 64'h1b3);
    endfunction
endpackage
`default_nettype wire

/* src/hashed_path_route_table.sv */
//------------------------------------------------------------------------------
// hashed_path_route_table
// Route table keyed by (path, method): FNV-1a hash, linear probing.
//------------------------------------------------------------------------------
// Requests carry at most one path byte each and are taken when start is high
// and busy is low. Bytes that are not last are absorbed while busy stays low:
// the running hash and the key buffer update. The request marked last starts the
// table operation and raises busy until its result is issued.
// A result is shown for one cycle with o_strobe; the receiver cannot stall.
// Operation after the last byte: a hash step, then per probed slot a metadata
// read and check plus a compare step per key byte; an insert that lands then
// copies the key buffer into the key memory. A lookup miss on a nonzero
// method reruns the probe with method 0. The slot and key memories each have
// a single read port; no new request is taken while busy. Early exits in the
// hash step: too long, full, insert of the empty route, empty lookup prefix.
// Reset empties the table by clearing per-slot valid flops; no sweep.
//------------------------------------------------------------------------------
`default_nettype none
module hashed_path_route_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_path_byte,
    input  wire logic        i_path_empty,
    input  wire logic        i_last,
    input  wire logic [7:0]  i_method,
    input  wire logic [15:0] i_route_index,
    output logic             o_strobe,
    output logic [15:0]      o_found_route,
    output logic [2:0]       o_status
);
    import hprt_pkg::*;

    t_meta       meta_mem [TABLE_SLOTS];
    logic [7:0]  key_mem  [TABLE_SLOTS * MAX_PATH_BYTES];
    logic [7:0]  kbuf_mem [MAX_PATH_BYTES];
    logic [TABLE_SLOTS-1:0] r_valid;

    t_state r_state, n_state;
    logic [63:0]       r_run_hash, n_run_hash, r_pre_hash, n_pre_hash;
    logic [LEN_W-1:0]  r_key_len, n_key_len, r_pre_len, n_pre_len;
    logic              r_query, n_query, r_too_long, n_too_long;
    logic              r_op, n_op, r_retry, n_retry;
    logic [7:0]        r_meth, n_meth;
    logic [15:0]       r_route, n_route;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [STEP_W-1:0] r_step, n_step;
    logic [LEN_W-1:0]  r_j, n_j, r_cpj, n_cpj;
    logic              r_cpv, n_cpv;
    logic [SLOT_W:0]   r_count, n_count;
    logic              n_strobe;
    logic [15:0]       n_found;
    logic [2:0]        n_status;

    t_meta             meta_q, meta_wd;
    logic              vld_q, meta_we, key_we, kbuf_we, set_valid;
    logic [7:0]        key_q, kbuf_q, key_wd;
    logic [KEY_AW-1:0] key_ra, key_wa;
    logic [BYTE_W-1:0] kbuf_ra;
    logic [LEN_W-1:0]  len_sel;
    logic [63:0]       start_hash;
    logic              accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign len_sel = r_op ? r_pre_len : r_key_len;
    assign kbuf_we = accept && !i_path_empty && (r_key_len < LEN_W'(MAX_PATH_BYTES));

    always_ff @(posedge i_clk) begin
        meta_q <= meta_mem[r_idx];
        vld_q  <= r_valid[r_idx];
        if (meta_we) begin
            meta_mem[r_idx] <= meta_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        key_q <= key_mem[key_ra];
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        kbuf_q <= kbuf_mem[kbuf_ra];
        if (kbuf_we) begin
            kbuf_mem[r_key_len[BYTE_W-1:0]] <= i_path_byte;
        end
    end

    always_comb begin
        n_state = r_state;  n_run_hash = r_run_hash; n_pre_hash = r_pre_hash;
        n_key_len = r_key_len; n_pre_len = r_pre_len; n_query = r_query;
        n_too_long = r_too_long; n_op = r_op; n_retry = r_retry; n_meth = r_meth;
        n_route = r_route; n_idx = r_idx; n_step = r_step; n_j = r_j;
        n_cpj = r_cpj; n_cpv = 1'b0; n_count = r_count;
        n_strobe = 1'b0; n_found = EMPTY_ROUTE; n_status = ST_LOOKUP;
        meta_we = 1'b0; key_we = 1'b0; set_valid = 1'b0;
        meta_wd = '{route: r_route, method: r_meth, length: r_key_len};
        key_ra = {r_idx, r_j[BYTE_W-1:0]};
        key_wa = {r_idx, r_cpj[BYTE_W-1:0]};
        key_wd = kbuf_q;
        kbuf_ra = r_j[BYTE_W-1:0];
        start_hash = fnv_byte(r_op ? r_pre_hash : r_run_hash, r_meth);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_path_empty) begin
                        if (r_key_len >= LEN_W'(MAX_PATH_BYTES)) begin
                            n_too_long = 1'b1;
                        end else begin
                            n_key_len  = r_key_len + 1'b1;
                            n_run_hash = fnv_byte(r_run_hash, i_path_byte);
                            if (!r_query) begin
                                if (i_path_byte == CHAR_QUERY || i_path_byte == CHAR_HASH) begin
                                    n_query = 1'b1;
                                end else begin
                                    n_pre_hash = fnv_byte(r_pre_hash, i_path_byte);
                                    n_pre_len  = r_pre_len + 1'b1;
                                end
                            end
                        end
                    end
                    if (i_last) begin
                        n_op = i_opcode; n_meth = i_method; n_route = i_route_index;
                        n_retry = 1'b0;
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                n_idx  = start_hash[SLOT_W-1:0];
                n_step = '0;
                n_state = S_READ;
                if (r_too_long) begin
                    n_strobe = 1'b1; n_status = ST_TOO_LONG; n_state = S_IDLE;
                end else if (!r_op && r_route == EMPTY_ROUTE) begin
                    n_strobe = 1'b1; n_status = ST_INSERTED; n_state = S_IDLE;
                end else if (!r_op && r_count >= (SLOT_W+1)'(HALF_SLOTS)) begin
                    n_strobe = 1'b1; n_status = ST_FULL; n_state = S_IDLE;
                end else if (r_op && r_pre_len == '0) begin
                    n_strobe = 1'b1; n_status = ST_LOOKUP; n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!vld_q) begin
                    if (!r_op) begin
                        n_j = '0; n_state = S_COPY;
                    end else if (r_meth != 8'd0 && !r_retry) begin
                        n_meth = 8'd0; n_retry = 1'b1; n_state = S_HASH;
                    end else begin
                        n_strobe = 1'b1; n_status = ST_LOOKUP; n_state = S_IDLE;
                    end
                end else if (meta_q.method == r_meth && meta_q.length == len_sel) begin
                    if (len_sel == '0) begin
                        n_strobe = 1'b1; n_state = S_IDLE;
                        n_status = r_op ? ST_LOOKUP : ST_DUPLICATE;
                        n_found  = r_op ? meta_q.route : EMPTY_ROUTE;
                    end else begin
                        n_j = '0; key_ra = {r_idx, {BYTE_W{1'b0}}};
                        kbuf_ra = '0; n_state = S_COMPARE;
                    end
                end else begin
                    n_state = S_READ;
                    n_step = r_step + 1'b1; n_idx = r_idx + 1'b1;
                end
                if (n_state == S_READ && r_step == STEP_W'(TABLE_SLOTS - 1)) begin
                    if (!r_op) begin
                        n_strobe = 1'b1; n_status = ST_FULL; n_state = S_IDLE;
                    end else if (r_meth != 8'd0 && !r_retry) begin
                        n_meth = 8'd0; n_retry = 1'b1; n_state = S_HASH;
                    end else begin
                        n_strobe = 1'b1; n_status = ST_LOOKUP; n_state = S_IDLE;
                    end
                end
            end
            S_COMPARE: begin
                if (key_q != kbuf_q) begin
                    n_state = S_READ;
                    n_step = r_step + 1'b1; n_idx = r_idx + 1'b1;
                    if (r_step == STEP_W'(TABLE_SLOTS - 1)) begin
                        if (!r_op) begin
                            n_strobe = 1'b1; n_status = ST_FULL; n_state = S_IDLE;
                        end else if (r_meth != 8'd0 && !r_retry) begin
                            n_meth = 8'd0; n_retry = 1'b1; n_state = S_HASH;
                        end else begin
                            n_strobe = 1'b1; n_status = ST_LOOKUP; n_state = S_IDLE;
                        end
                    end
                end else if (r_j == len_sel - 1'b1) begin
                    n_strobe = 1'b1; n_state = S_IDLE;
                    n_status = r_op ? ST_LOOKUP : ST_DUPLICATE;
                    n_found  = r_op ? meta_q.route : EMPTY_ROUTE;
                end else begin
                    n_j = r_j + 1'b1;
                    key_ra  = {r_idx, n_j[BYTE_W-1:0]};
                    kbuf_ra = n_j[BYTE_W-1:0];
                end
            end
            S_COPY: begin
                key_we = r_cpv;
                if (r_j < r_key_len) begin
                    n_j = r_j + 1'b1; n_cpj = r_j; n_cpv = 1'b1;
                end else if (!r_cpv) begin
                    meta_we = 1'b1; set_valid = 1'b1; n_count = r_count + 1'b1;
                    n_strobe = 1'b1; n_status = ST_INSERTED; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (n_strobe) begin
            n_run_hash = FNV_BASIS; n_pre_hash = FNV_BASIS;
            n_key_len = '0; n_pre_len = '0; n_query = 1'b0; n_too_long = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run_hash <= FNV_BASIS; r_pre_hash <= FNV_BASIS;
            r_key_len <= '0; r_pre_len <= '0; r_query <= 1'b0; r_too_long <= 1'b0;
            r_count <= '0; r_valid <= '0; r_cpv <= 1'b0; o_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run_hash <= n_run_hash; r_pre_hash <= n_pre_hash;
            r_key_len <= n_key_len; r_pre_len <= n_pre_len;
            r_query <= n_query; r_too_long <= n_too_long;
            r_count <= n_count; r_cpv <= n_cpv; o_strobe <= n_strobe;
            if (set_valid) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_retry <= n_retry; r_meth <= n_meth; r_route <= n_route;
        r_idx <= n_idx; r_step <= n_step; r_j <= n_j; r_cpj <= n_cpj;
        o_found_route <= n_found;
        o_status <= n_status;
    end
endmodule
`default_nettype wire
